@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the transmitter RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold in the same cycle as trig
`define ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");

// cond must hold in the cycle after trig
`define ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/sfpw_pkg.sv @@
// Package for the pulse-width frame transmitter: register map, reset
// values and the structs passed between its modules. No dependencies.
package sfpw_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    REG_SHORT_UNITS    = 2'd0,
    REG_LONG_UNITS     = 2'd1,
    REG_SYNC_LOW_UNITS = 2'd2,
    REG_REPEAT_TOTAL   = 2'd3
  } reg_index_t;

  localparam logic [7:0] ShortUnitsReset   = 8'd4;
  localparam logic [7:0] LongUnitsReset    = 8'd12;
  localparam logic [7:0] SyncLowUnitsReset = 8'd124;
  localparam logic [3:0] RepeatTotalReset  = 4'd10;

  localparam logic [5:0] SyncPosition = 6'd32;

  typedef struct packed {
    logic [7:0] short_units;
    logic [7:0] long_units;
    logic [7:0] sync_low_units;
    logic [3:0] repeat_total;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic start_ignored;
  } res_t;

endpackage

@@ hw/rtl/sfpw_regs.sv @@
// APB-style configuration registers of the frame transmitter.
// Depends on sfpw_pkg.
module sfpw_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfpw_pkg::AddrWidth-1:0]  paddr,
  input  logic [sfpw_pkg::DataWidth-1:0]  pwdata,
  output logic [sfpw_pkg::DataWidth-1:0]  prdata,
  output logic                            pready,
  output sfpw_pkg::cfg_t                  cfg
);
  import sfpw_pkg::*;

  reg_index_t index;
  logic       wr_en;

  assign index  = reg_index_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_units    <= ShortUnitsReset;
      cfg.long_units     <= LongUnitsReset;
      cfg.sync_low_units <= SyncLowUnitsReset;
      cfg.repeat_total   <= RepeatTotalReset;
    end else if (wr_en) begin
      unique case (index)
        REG_SHORT_UNITS:    cfg.short_units    <= pwdata[7:0];
        REG_LONG_UNITS:     cfg.long_units     <= pwdata[7:0];
        REG_SYNC_LOW_UNITS: cfg.sync_low_units <= pwdata[7:0];
        REG_REPEAT_TOTAL:   cfg.repeat_total   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      REG_SHORT_UNITS:    prdata = {24'd0, cfg.short_units};
      REG_LONG_UNITS:     prdata = {24'd0, cfg.long_units};
      REG_SYNC_LOW_UNITS: prdata = {24'd0, cfg.sync_low_units};
      REG_REPEAT_TOTAL:   prdata = {28'd0, cfg.repeat_total};
      default:            prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/sfpw_encoder.sv @@
// Frame state and pulse-width encoder: one word per step, one result.
// Depends on sfpw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfpw_encoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            command,
  input  logic [7:0]      node_id,
  input  logic [3:0]      node_kind,
  input  logic [9:0]      sample,
  input  logic [3:0]      rate_code,
  input  logic [1:0]      batt_class,
  input  sfpw_pkg::cfg_t  cfg,
  output sfpw_pkg::res_t  res
);
  import sfpw_pkg::*;

  logic [31:0] frame_word, frame_word_next;
  logic [5:0]  bit_position, bit_position_next;
  logic [3:0]  repeats_done, repeats_done_next;
  logic        low_phase, low_phase_next;
  logic [7:0]  phase_ticks_left, phase_ticks_left_next;
  logic        active, active_next;

  logic [31:0] load_word;
  logic [3:0]  checksum;
  logic [7:0]  ticks_dec;
  logic [3:0]  repeats_inc;
  logic [3:0]  total;

  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [7:0] phase_len(input cfg_t c, input logic [31:0] w,
                                           input logic [5:0] pos, input logic is_low);
    logic one;
    logic use_long;
    one      = w[pos[4:0]];
    use_long = is_low ? !one : one;
    if (pos >= SyncPosition) begin
      return at_least_one(is_low ? c.sync_low_units : c.short_units);
    end
    return at_least_one(use_long ? c.long_units : c.short_units);
  endfunction

  assign checksum = node_id[7:4] ^ node_id[3:0] ^ node_kind ^ sample[9:6] ^ sample[5:2]
                  ^ {sample[1:0], rate_code[3:2]} ^ {rate_code[1:0], batt_class};
  assign load_word   = {node_id, node_kind, sample, rate_code, batt_class, checksum};
  assign ticks_dec   = (phase_ticks_left == 8'd0) ? 8'd0 : phase_ticks_left - 8'd1;
  assign repeats_inc = repeats_done + 4'd1;
  assign total       = (cfg.repeat_total == 4'd0) ? 4'd1 : cfg.repeat_total;

  always_comb begin
    frame_word_next       = frame_word;
    bit_position_next     = bit_position;
    repeats_done_next     = repeats_done;
    low_phase_next        = low_phase;
    phase_ticks_left_next = phase_ticks_left;
    active_next           = active;
    res                   = '0;
    if (command) begin
      res.busy_res = 1'b1;
      if (active) begin
        res.start_ignored = 1'b1;
      end else begin
        frame_word_next       = load_word;
        bit_position_next     = 6'd0;
        repeats_done_next     = 4'd0;
        low_phase_next        = 1'b0;
        active_next           = 1'b1;
        phase_ticks_left_next = phase_len(cfg, load_word, 6'd0, 1'b0);
      end
    end else if (active) begin
      res.busy_res          = 1'b1;
      res.line_level        = !low_phase;
      phase_ticks_left_next = ticks_dec;
      if (ticks_dec == 8'd0) begin
        if (!low_phase) begin
          low_phase_next        = 1'b1;
          phase_ticks_left_next = phase_len(cfg, frame_word, bit_position, 1'b1);
        end else begin
          low_phase_next = 1'b0;
          if (bit_position < SyncPosition) begin
            bit_position_next = bit_position + 6'd1;
          end else begin
            bit_position_next = 6'd0;
            repeats_done_next = repeats_inc;
            if (repeats_inc >= total) begin
              active_next       = 1'b0;
              res.frame_done    = 1'b1;
              repeats_done_next = 4'd0;
            end
          end
          if (active_next) begin
            phase_ticks_left_next = phase_len(cfg, frame_word, bit_position_next, 1'b0);
          end else begin
            phase_ticks_left_next = 8'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_word       <= '0;
      bit_position     <= '0;
      repeats_done     <= '0;
      low_phase        <= 1'b0;
      phase_ticks_left <= '0;
      active           <= 1'b0;
    end else if (step) begin
      frame_word       <= frame_word_next;
      bit_position     <= bit_position_next;
      repeats_done     <= repeats_done_next;
      low_phase        <= low_phase_next;
      phase_ticks_left <= phase_ticks_left_next;
      active           <= active_next;
    end
  end

  `ASSERT_SAME(a_pos_range, active, bit_position <= SyncPosition)
  `ASSERT_SAME(a_done_excl, res.frame_done, res.busy_res && !res.start_ignored)
  `ASSERT_NEXT(a_done_idle, step && res.frame_done, !active && phase_ticks_left == 8'd0)
  `ASSERT_SAME(a_ticks_live, active, phase_ticks_left != 8'd0)

endmodule

@@ hw/rtl/sensor_frame_pulse_width_transmitter_core.sv @@
// Pulse-width on-off-keyed frame transmitter. Of the input words, a start word
// loads a 32-bit frame and a tick word advances the line by one time unit. Each
// word gives one result word in the next cycle, held in the output register; a new
// word is taken every cycle as long as that register is empty or being read, so
// the block sustains one word per clock. Depends on sfpw_pkg, sfpw_regs,
// sfpw_encoder and assert_macros.svh.
`include "assert_macros.svh"

module sensor_frame_pulse_width_transmitter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfpw_pkg::AddrWidth-1:0]  paddr,
  input  logic [sfpw_pkg::DataWidth-1:0]  pwdata,
  output logic [sfpw_pkg::DataWidth-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [7:0]                      node_id,
  input  logic [3:0]                      node_kind,
  input  logic [9:0]                      sample,
  input  logic [3:0]                      rate_code,
  input  logic [1:0]                      batt_class,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            line_level,
  output logic                            busy_res,
  output logic                            frame_done,
  output logic                            start_ignored
);
  import sfpw_pkg::*;

  cfg_t cfg;
  res_t res_comb;
  res_t res_q;
  logic step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  sfpw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfpw_encoder u_encoder (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .command    (command),
    .node_id    (node_id),
    .node_kind  (node_kind),
    .sample     (sample),
    .rate_code  (rate_code),
    .batt_class (batt_class),
    .cfg        (cfg),
    .res        (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_comb;
    end
  end

  assign line_level    = res_q.line_level;
  assign busy_res      = res_q.busy_res;
  assign frame_done    = res_q.frame_done;
  assign start_ignored = res_q.start_ignored;

  `ASSERT_NEXT(a_step_fills, step, out_valid)
  `ASSERT_SAME(a_no_overrun, out_valid && !out_ready, !step)

endmodule

@@ dv/sensor_frame_pulse_width_transmitter_core_tb.sv @@
// Self-checking testbench for sensor_frame_pulse_width_transmitter_core: drives start/tick words
// and APB register writes, predicts every result word and compares each field.
// Depends on sfpw_pkg and the core RTL only.
module sensor_frame_pulse_width_transmitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfpw_pkg::*;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic                 command;
  logic [7:0]           node_id;
  logic [3:0]           node_kind;
  logic [9:0]           sample;
  logic [3:0]           rate_code;
  logic [1:0]           batt_class;
  logic                 out_valid;
  logic                 out_ready;
  logic                 line_level;
  logic                 busy_res;
  logic                 frame_done;
  logic                 start_ignored;

  sensor_frame_pulse_width_transmitter_core DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .node_id       (node_id),
    .node_kind     (node_kind),
    .sample        (sample),
    .rate_code     (rate_code),
    .batt_class    (batt_class),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .line_level    (line_level),
    .busy_res      (busy_res),
    .frame_done    (frame_done),
    .start_ignored (start_ignored)
  );

  // transmitter mirror
  cfg_t        cfg;
  logic [31:0] frame_bits;
  logic [5:0]  bit_idx;
  logic [3:0]  frames_sent;
  logic        in_low;
  logic [7:0]  ticks_left;
  logic        sending;

  res_t expected_lines[$];
  res_t seen_line;

  int errors;
  int word_total;
  int start_total;
  int ignored_total;
  int done_total;
  int random_words;
  bit gaps_on;
  bit stall_on;
  int hold_off;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] phase_len(input logic [5:0] pos, input logic low);
    logic [7:0] v;
    logic       one;
    if (pos >= SyncPosition) begin
      v = low ? cfg.sync_low_units : cfg.short_units;
    end else begin
      one = frame_bits[pos[4:0]];
      v = (low ? !one : one) ? cfg.long_units : cfg.short_units;
    end
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic res_t step_line(input logic cmd, input logic [7:0] id,
                                     input logic [3:0] ntype, input logic [9:0] smp,
                                     input logic [3:0] rate, input logic [1:0] batt);
    res_t        r;
    logic [31:0] w;
    logic [3:0]  chk;
    logic [3:0]  total;
    r = '0;
    if (cmd == CMD_START) begin
      r.busy_res = 1'b1;
      if (sending) begin
        r.start_ignored = 1'b1;
      end else begin
        w = {id, ntype, smp, rate, batt, 4'h0};
        chk = 4'h0;
        for (int i = 1; i < 8; i++) chk ^= w[4*i +: 4];
        frame_bits   = w | {28'd0, chk};
        bit_idx      = '0;
        frames_sent  = '0;
        in_low       = 1'b0;
        sending      = 1'b1;
        ticks_left   = phase_len(6'd0, 1'b0);
      end
    end else if (sending) begin
      r.busy_res   = 1'b1;
      r.line_level = !in_low;
      if (ticks_left != 8'd0) ticks_left--;
      if (ticks_left == 8'd0) begin
        if (!in_low) begin
          in_low     = 1'b1;
          ticks_left = phase_len(bit_idx, 1'b1);
        end else begin
          in_low = 1'b0;
          if (bit_idx < SyncPosition) begin
            bit_idx++;
          end else begin
            total = (cfg.repeat_total == 4'd0) ? 4'd1 : cfg.repeat_total;
            frames_sent = frames_sent + 4'd1;
            bit_idx = '0;
            if (frames_sent >= total) begin
              sending      = 1'b0;
              r.frame_done = 1'b1;
              frames_sent  = '0;
            end
          end
          ticks_left = sending ? phase_len(bit_idx, 1'b0) : 8'd0;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic exp_bit, input logic got_bit);
    errors++;
    $display("%0t: %s mismatch, expected %0b got %0b", $time, what, exp_bit, got_bit);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("unexpected word", 1'b0, 1'b1);
      end else begin
        seen_line = expected_lines.pop_front();
        if (line_level !== seen_line.line_level)
          report_mismatch("line_level", seen_line.line_level, line_level);
        if (busy_res !== seen_line.busy_res)
          report_mismatch("busy_res", seen_line.busy_res, busy_res);
        if (frame_done !== seen_line.frame_done)
          report_mismatch("frame_done", seen_line.frame_done, frame_done);
        if (start_ignored !== seen_line.start_ignored)
          report_mismatch("start_ignored", seen_line.start_ignored, start_ignored);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
        out_ready = 1'b1;
      end else begin
        stall = pick_gap(stall_on);
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready = 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_SHORT_UNITS:    cfg.short_units    = value[7:0];
      REG_LONG_UNITS:     cfg.long_units     = value[7:0];
      REG_SYNC_LOW_UNITS: cfg.sync_low_units = value[7:0];
      REG_REPEAT_TOTAL:   cfg.repeat_total   = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_all(input logic [7:0] s, input logic [7:0] l, input logic [7:0] y,
                           input logic [3:0] n);
    write_reg(REG_SHORT_UNITS, {24'd0, s});
    write_reg(REG_LONG_UNITS, {24'd0, l});
    write_reg(REG_SYNC_LOW_UNITS, {24'd0, y});
    write_reg(REG_REPEAT_TOTAL, {28'd0, n});
  endtask

  task automatic send_word(input logic cmd, input logic [7:0] id, input logic [3:0] ntype,
                           input logic [9:0] smp, input logic [3:0] rate,
                           input logic [1:0] batt);
    int   gap;
    res_t r;
    gap = pick_gap(gaps_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    command       = cmd;
    node_id       = id;
    node_kind     = ntype;
    sample        = smp;
    rate_code     = rate;
    batt_class    = batt;
    do @(posedge clk); while (!in_ready);
    r = step_line(cmd, id, ntype, smp, rate, batt);
    expected_lines.push_back(r);
    word_total++;
    if (cmd == CMD_START) start_total++;
    if (r.start_ignored) ignored_total++;
    if (r.frame_done) done_total++;
  endtask

  task automatic send_start_random();
    send_word(CMD_START, 8'($urandom), 4'($urandom), 10'($urandom), 4'($urandom),
              2'($urandom));
  endtask

  // other fields carry junk on ticks
  task automatic send_tick();
    send_word(CMD_TICK, 8'($urandom), 4'($urandom), 10'($urandom), 4'($urandom),
              2'($urandom));
  endtask

  task automatic tick_until_idle();
    while (sending) send_tick();
  endtask

  task automatic wait_lines_out();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic test_defaults_and_idle();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    repeat (3) send_tick();
    send_word(CMD_START, 8'hA5, 4'h3, 10'h2C7, 4'h9, 2'h1);
    repeat (20) send_tick();
    send_start_random();
    wait_lines_out();
    // shrink mid-frame: current phase keeps its old length
    write_all(8'd1, 8'd2, 8'd1, 4'd1);
    tick_until_idle();
    wait_lines_out();
  endtask

  task automatic test_frame_extremes();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    send_word(CMD_START, 8'hFF, 4'hF, 10'h3FF, 4'hF, 2'h3);
    tick_until_idle();
    send_word(CMD_START, 8'h00, 4'h0, 10'h000, 4'h0, 2'h0);
    tick_until_idle();
    wait_lines_out();
  endtask

  task automatic test_zero_registers();
    write_all(8'd0, 8'd0, 8'd0, 4'd0);
    send_start_random();
    send_start_random();
    tick_until_idle();
    send_tick();
    wait_lines_out();
  endtask

  task automatic test_max_registers();
    write_all(8'd255, 8'd255, 8'd255, 4'd15);
    send_start_random();
    repeat (10) send_tick();
    send_start_random();
    wait_lines_out();
    write_all(8'd2, 8'd1, 8'd3, 4'd1);
    tick_until_idle();
    wait_lines_out();
  endtask

  task automatic test_output_backpressure();
    write_all(8'd1, 8'd2, 8'd2, 4'd2);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    hold_off = 80;
    send_start_random();
    repeat (40) send_tick();
    wait_lines_out();
    tick_until_idle();
    wait_lines_out();
  endtask

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'd0;
    if (r == 15) return 8'($urandom_range(3, 255));
    return 8'($urandom_range(1, 2));
  endfunction

  // directed tests above already send close to a thousand words
  task automatic test_random_traffic();
    int burst;
    while (random_words < 120) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) write_reg(REG_SHORT_UNITS, {24'd0, pick_len()});
      if ($urandom_range(0, 1)) write_reg(REG_LONG_UNITS, {24'd0, pick_len()});
      if ($urandom_range(0, 1)) write_reg(REG_SYNC_LOW_UNITS, {24'd0, pick_len()});
      if ($urandom_range(0, 1)) begin
        write_reg(REG_REPEAT_TOTAL,
                  {28'd0, ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2))});
      end
      burst = $urandom_range(20, 120);
      repeat (burst) begin
        if (!sending ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 39) == 0))
          send_start_random();
        else
          send_tick();
        random_words++;
      end
      wait_lines_out();
    end
  endtask

  initial begin
    #20_000_000;
    $display("sensor_frame_pulse_width_transmitter_core_tb: errors");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    command       = CMD_TICK;
    node_id       = '0;
    node_kind     = '0;
    sample        = '0;
    rate_code     = '0;
    batt_class    = '0;
    gaps_on       = 1'b0;
    stall_on      = 1'b0;
    hold_off      = 0;
    errors        = 0;
    cfg           = '{ShortUnitsReset, LongUnitsReset, SyncLowUnitsReset, RepeatTotalReset};
    frame_bits    = '0;
    bit_idx       = '0;
    frames_sent   = '0;
    in_low        = 1'b0;
    ticks_left    = '0;
    sending       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_defaults_and_idle();
    test_frame_extremes();
    test_zero_registers();
    test_max_registers();
    test_output_backpressure();
    test_random_traffic();

    wait_lines_out();
    repeat (10) @(posedge clk);
    $display("run: %0d words, %0d starts (%0d while busy), %0d frames completed",
             word_total, start_total, ignored_total, done_total);
    $display("run: default, zero, max and random register settings, long output hold-off");
    if (errors == 0)
      $display("sensor_frame_pulse_width_transmitter_core_tb: clean");
    else
      $display("sensor_frame_pulse_width_transmitter_core_tb: errors");
    $finish;
  end

endmodule
